>>> rtl/dqw_pkg.sv
// dqw_pkg: shared types and constants of the distance-band weight interpolator
// holds the sequencer state type, step counts, command codes and the exp2 factor table
// no dependencies
package dqw_pkg;

  // command codes carried in tuser
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BANDS  = 2'd2;

  // iteration counts of the shared units
  localparam int DIV_STEPS = 48;
  localparam int LOG_STEPS = 24;
  localparam int POW_STEPS = 30;

  // sqrt(2) + 1e-6 in Q16, rounded
  localparam logic [31:0] MAX_DIST_Q16 = 32'd92682;

  // floor(2^48 / MAX_DIST_Q16), reciprocal for the band position
  localparam logic [31:0] DIST_RECIP = 32'((64'd1 << 48) / 64'(MAX_DIST_Q16));

  // Q30 one, exp2 start value
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LD_MUL,
    S_DIV_LD,
    S_LD_WR,
    S_Q_START,
    S_DIV_X,
    S_DIV_Y,
    S_SQ_X,
    S_SQ_Y,
    S_SQRT,
    S_SP_MUL,
    S_SP_RCP,
    S_SP_FIX,
    S_SP_ADJ,
    S_SEL,
    S_RD_EDGE,
    S_EDGE,
    S_RD_A,
    S_RD_B,
    S_CHECK,
    S_NORM,
    S_LOG,
    S_INTERP,
    S_POW,
    S_SHIFT,
    S_FINISH
  } state_e;

  typedef logic [POW_STEPS-1:0][31:0] pow2_tab_t;

  // floored integer square root, elaboration time only
  function automatic logic [63:0] isqrt_const(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = 64'd0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(2^-k) in Q30 for k = 1 .. POW_STEPS, each the root of the one before
  function automatic pow2_tab_t pow2_table();
    pow2_tab_t tab;
    logic [63:0] c;
    c = isqrt_const(64'h2000_0000_0000_0000);
    for (int k = 0; k < POW_STEPS; k++) begin
      tab[k] = c[31:0];
      c = isqrt_const(c << 30);
    end
    return tab;
  endfunction

  localparam pow2_tab_t POW2_C = pow2_table();

  // apply a sign to a magnitude and saturate to signed 32 bits
  function automatic logic [31:0] sat_band(input logic neg, input logic [47:0] mag);
    logic [31:0] res;
    if (!neg) begin
      res = (mag > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end else begin
      res = (mag > 48'h0000_8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
    end
    return res;
  endfunction

  // clamp a signed band to an unsigned weight
  function automatic logic [31:0] clamp_weight(input logic [31:0] v);
    return (v[31] || v == 32'd0) ? 32'd0 : v;
  endfunction

endpackage

>>> rtl/dct_quant_weight_interpolator.sv
// dct_quant_weight_interpolator: band table builder and geometric weight interpolator
// one sequencer around a shared 32x32 multiplier, a restoring divider and a root unit
// depends on dqw_pkg
//
//  channel   dir   handshake                      payload
//  s_axis    in    s_axis_tvalid / s_axis_tready  tdata: band, param, column, row; tuser: cmd
//  m_axis    out   m_axis_tvalid / m_axis_tready  tdata: weight, error flag
//  cfg       in    cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// a load writes the base band directly, multiplies the previous band for a growing
// band and divides it in the 48 step divider for a shrinking band
// a query runs two 48 step divisions, a 17 step root, a reciprocal multiply with
// one correction step, two log2 passes of normalize steps and 24 squaring steps,
// and 30 exp2 steps
// s_axis_tready is high only while the sequencer idles; a result waits in the
// output register, and the sequencer holds its last state while that is full
// reset clears the configuration to 8 x 8 with one band, the error and previous band;
// the band table itself holds no reset value
module dct_quant_weight_interpolator #(
  parameter int MAX_BANDS = 16,
  parameter int MAX_DIM   = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] band_index, [35:4] param_value, [43:36] column, [51:44] row_number, rest zero
  input  logic [55:0] s_axis_tdata,
  // [0] command
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] weight_value, [32] error_flag, rest zero
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);

  localparam int BW = $clog2(MAX_BANDS);
  localparam int NW = $clog2(MAX_BANDS + 1);

  // input fields
  logic               in_cmd;
  logic [3:0]         in_bidx;
  logic signed [31:0] in_x;
  logic [7:0]         in_col;
  logic [7:0]         in_row;
  logic               in_fire;
  logic               bidx_ok;

  assign in_cmd  = s_axis_tuser[0];
  assign in_bidx = s_axis_tdata[3:0];
  assign in_x    = $signed(s_axis_tdata[35:4]);
  assign in_col  = s_axis_tdata[43:36];
  assign in_row  = s_axis_tdata[51:44];
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign bidx_ok = 32'(in_bidx) < MAX_BANDS;

  dqw_pkg::state_e state_q, state_d;

  logic [8:0] mw_q, mh_q;
  logic [4:0] bc_q;

  logic               err_q, err_d;
  logic signed [31:0] prev_q, prev_d;
  logic [31:0]        band_q, band_d;
  logic               neg_q, neg_d;
  logic [3:0]         bidx_q, bidx_d;
  logic signed [31:0] x_q, x_d;
  logic [7:0]         col_q, col_d;
  logic [7:0]         row_q, row_d;
  logic [5:0]         cnt_q, cnt_d;

  logic [31:0] div_rem_q, div_rem_d;
  logic [47:0] div_quo_q, div_quo_d;
  logic [31:0] div_den_q, div_den_d;

  logic [16:0] dx_q, dx_d;
  logic [16:0] dy_q, dy_d;
  logic [33:0] sq_v_q, sq_v_d;
  logic [33:0] sq_r_q, sq_r_d;
  logic [33:0] sq_b_q, sq_b_d;

  logic [NW-1:0] n_q, n_d;
  logic [BW-1:0] idx_q, idx_d;
  logic [15:0]   fr_q, fr_d;
  logic [31:0]   sp_q, sp_d;
  logic [31:0]   a_q, a_d;
  logic [31:0]   b_q, b_d;
  logic [31:0]   m_q, m_d;
  logic [4:0]    p_q, p_d;
  logic [23:0]   f_q, f_d;
  logic signed [29:0] la_q, la_d;
  logic signed [29:0] lb_q, lb_d;
  logic          second_q, second_d;
  logic signed [47:0] t_q, t_d;
  logic [31:0]   e_q, e_d;
  logic [31:0]   res_q, res_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_w_q, out_w_d;
  logic        out_e_q, out_e_d;
  logic        out_free;

  // band table memory
  logic [31:0]   band_mem [MAX_BANDS];
  logic [31:0]   rd_q;
  logic          mem_we;
  logic [BW-1:0] mem_ra;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // divider step
  logic [32:0] div_rs;
  logic        div_ge;
  logic [31:0] div_rem_n;
  logic [47:0] div_quo_n;
  logic        div_done;
  assign div_rs    = {div_rem_q, div_quo_q[47]};
  assign div_ge    = div_rs >= {1'b0, div_den_q};
  assign div_rem_n = div_ge ? 32'(div_rs - {1'b0, div_den_q}) : div_rs[31:0];
  assign div_quo_n = {div_quo_q[46:0], div_ge};
  assign div_done  = cnt_q == 6'(dqw_pkg::DIV_STEPS - 1);

  // band position after the reciprocal estimate, at most one short
  logic [31:0] sp_fix;
  assign sp_fix = (div_rem_q >= dqw_pkg::MAX_DIST_Q16) ? (sp_q + 32'd1) : sp_q;

  // root step
  logic [33:0] sq_sum;
  logic        sq_ge;
  logic [33:0] sq_r_n;
  assign sq_sum = sq_r_q + sq_b_q;
  assign sq_ge  = sq_v_q >= sq_sum;
  assign sq_r_n = sq_ge ? ((sq_r_q >> 1) + sq_b_q) : (sq_r_q >> 1);

  // magnitudes for the load path
  logic [31:0] abs_prev, abs_x;
  assign abs_prev = prev_q[31] ? (~prev_q + 32'd1) : prev_q;
  assign abs_x    = in_x[31] ? (~in_x + 32'd1) : in_x;

  // clamped matrix sizes and positions
  logic [8:0] wsz, hsz;
  logic [7:0] xpos, ypos;
  logic [NW-1:0] nb;
  always_comb begin
    wsz = (mw_q == 9'd0) ? 9'd1 : mw_q;
    if (wsz > 9'(MAX_DIM)) wsz = 9'(MAX_DIM);
    hsz = (mh_q == 9'd0) ? 9'd1 : mh_q;
    if (hsz > 9'(MAX_DIM)) hsz = 9'(MAX_DIM);
    xpos = ({1'b0, col_q} > wsz - 9'd1) ? 8'(wsz - 9'd1) : col_q;
    ypos = ({1'b0, row_q} > hsz - 9'd1) ? 8'(hsz - 9'd1) : row_q;
    nb   = (32'(bc_q) > MAX_BANDS) ? NW'(MAX_BANDS) : NW'(bc_q);
  end

  // log2 squaring step
  logic [31:0] log_mm;
  logic [23:0] log_f_n;
  logic [5:0]  log_pm16;
  logic        log_done;
  assign log_mm   = mul_p[61:30];
  assign log_f_n  = f_q | (log_mm[31] ? (24'd1 << (5'(dqw_pkg::LOG_STEPS - 1) - cnt_q[4:0]))
                                      : 24'd0);
  assign log_pm16 = {1'b0, p_q} - 6'd16;
  assign log_done = cnt_q == 6'(dqw_pkg::LOG_STEPS - 1);

  // interpolation of the logs
  logic signed [30:0] lg_diff;
  logic [31:0]        lg_mag;
  logic signed [47:0] la_ext;
  assign lg_diff = 31'(lb_q) - 31'(la_q);
  assign lg_mag  = lg_diff[30] ? 32'(-lg_diff) : 32'(lg_diff);
  assign la_ext  = $signed({{2{la_q[29]}}, la_q, 16'd0});

  // exp2 step
  logic pow_bit;
  logic pow_done;
  assign pow_bit  = t_q[6'd39 - cnt_q];
  assign pow_done = cnt_q == 6'(dqw_pkg::POW_STEPS - 1);

  // final scale by the integer part
  logic signed [8:0] sh_s;
  logic [8:0]        sh_n;
  logic [63:0]       sh_wide;
  logic [31:0]       sh_res;
  always_comb begin
    sh_s    = $signed({t_q[47], t_q[47:40]}) - 9'sd14;
    sh_n    = 9'(-sh_s);
    sh_wide = {32'd0, e_q} << sh_s[4:0];
    if (!sh_s[8]) begin
      if (sh_s > 9'sd31) sh_res = 32'hFFFF_FFFF;
      else sh_res = (sh_wide[63:32] != 32'd0) ? 32'hFFFF_FFFF : sh_wide[31:0];
    end else begin
      sh_res = (sh_n > 9'd31) ? 32'd0 : (e_q >> sh_n[4:0]);
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dqw_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          if (in_cmd == dqw_pkg::CMD_QUERY) state_d = dqw_pkg::S_Q_START;
          else if (!bidx_ok) state_d = dqw_pkg::S_FINISH;
          else if (in_bidx == 4'd0) state_d = dqw_pkg::S_LD_WR;
          else if (in_x > 32'sd0) state_d = dqw_pkg::S_LD_MUL;
          else state_d = dqw_pkg::S_DIV_LD;
        end
      end
      dqw_pkg::S_LD_MUL: state_d = dqw_pkg::S_LD_WR;
      dqw_pkg::S_DIV_LD: if (div_done) state_d = dqw_pkg::S_LD_WR;
      dqw_pkg::S_LD_WR:  state_d = dqw_pkg::S_FINISH;
      dqw_pkg::S_Q_START: begin
        if (nb == NW'(0)) state_d = dqw_pkg::S_FINISH;
        else if (nb == NW'(1)) state_d = dqw_pkg::S_RD_EDGE;
        else state_d = dqw_pkg::S_DIV_X;
      end
      dqw_pkg::S_DIV_X:  if (div_done) state_d = dqw_pkg::S_DIV_Y;
      dqw_pkg::S_DIV_Y:  if (div_done) state_d = dqw_pkg::S_SQ_X;
      dqw_pkg::S_SQ_X:   state_d = dqw_pkg::S_SQ_Y;
      dqw_pkg::S_SQ_Y:   state_d = dqw_pkg::S_SQRT;
      dqw_pkg::S_SQRT:   if (sq_b_q == 34'd1) state_d = dqw_pkg::S_SP_MUL;
      dqw_pkg::S_SP_MUL: state_d = dqw_pkg::S_SP_RCP;
      dqw_pkg::S_SP_RCP: state_d = dqw_pkg::S_SP_FIX;
      dqw_pkg::S_SP_FIX: state_d = dqw_pkg::S_SP_ADJ;
      dqw_pkg::S_SP_ADJ: state_d = dqw_pkg::S_SEL;
      dqw_pkg::S_SEL: begin
        if ((NW + 1)'(idx_q) + (NW + 1)'(1) >= (NW + 1)'(n_q)) state_d = dqw_pkg::S_RD_EDGE;
        else state_d = dqw_pkg::S_RD_A;
      end
      dqw_pkg::S_RD_EDGE: state_d = dqw_pkg::S_EDGE;
      dqw_pkg::S_EDGE:    state_d = dqw_pkg::S_FINISH;
      dqw_pkg::S_RD_A:    state_d = dqw_pkg::S_RD_B;
      dqw_pkg::S_RD_B:    state_d = dqw_pkg::S_CHECK;
      dqw_pkg::S_CHECK: begin
        if (a_q[31] || a_q == 32'd0 || rd_q[31] || rd_q == 32'd0 ||
            fr_q == 16'd0 || a_q == rd_q) state_d = dqw_pkg::S_FINISH;
        else state_d = dqw_pkg::S_NORM;
      end
      dqw_pkg::S_NORM:   if (m_q[30]) state_d = dqw_pkg::S_LOG;
      dqw_pkg::S_LOG: begin
        if (log_done) state_d = second_q ? dqw_pkg::S_INTERP : dqw_pkg::S_NORM;
      end
      dqw_pkg::S_INTERP: state_d = dqw_pkg::S_POW;
      dqw_pkg::S_POW:    if (pow_done) state_d = dqw_pkg::S_SHIFT;
      dqw_pkg::S_SHIFT:  state_d = dqw_pkg::S_FINISH;
      dqw_pkg::S_FINISH: if (out_free) state_d = dqw_pkg::S_IDLE;
      default:           state_d = dqw_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs of the sequencer
  always_comb begin
    err_d = err_q;       prev_d = prev_q;     band_d = band_q;   neg_d = neg_q;
    bidx_d = bidx_q;     x_d = x_q;           col_d = col_q;     row_d = row_q;
    cnt_d = cnt_q;       div_rem_d = div_rem_q; div_quo_d = div_quo_q;
    div_den_d = div_den_q; dx_d = dx_q;       dy_d = dy_q;
    sq_v_d = sq_v_q;     sq_r_d = sq_r_q;     sq_b_d = sq_b_q;
    n_d = n_q;           idx_d = idx_q;       fr_d = fr_q;       sp_d = sp_q;
    a_d = a_q;           b_d = b_q;           m_d = m_q;         p_d = p_q;
    f_d = f_q;           la_d = la_q;         lb_d = lb_q;       second_d = second_q;
    t_d = t_q;           e_d = e_q;           res_d = res_q;
    mul_a = 32'd0;       mul_b = 32'd0;
    mem_we = 1'b0;       mem_ra = idx_q;

    unique case (state_q)
      dqw_pkg::S_IDLE: begin
        if (in_fire) begin
          bidx_d = in_bidx;
          x_d    = in_x;
          col_d  = in_col;
          row_d  = in_row;
          res_d  = 32'd0;
          neg_d  = prev_q[31];
          band_d = in_x;
          div_quo_d = {abs_prev, 16'd0};
          div_den_d = 32'd65536 + abs_x;
          div_rem_d = 32'd0;
          cnt_d     = 6'd0;
        end
      end
      dqw_pkg::S_LD_MUL: begin
        mul_a  = abs_prev;
        mul_b  = x_q + 32'sd65536;
        band_d = dqw_pkg::sat_band(neg_q, mul_p[63:16]);
      end
      dqw_pkg::S_DIV_LD: begin
        div_rem_d = div_rem_n;
        div_quo_d = div_quo_n;
        cnt_d     = cnt_q + 6'd1;
        if (div_done) band_d = dqw_pkg::sat_band(neg_q, div_quo_n);
      end
      dqw_pkg::S_LD_WR: begin
        mem_we = 1'b1;
        prev_d = band_q;
        if (band_q[31] || band_q == 32'd0) err_d = 1'b1;
      end
      dqw_pkg::S_Q_START: begin
        n_d       = nb;
        div_quo_d = {24'd0, xpos, 16'd0};
        div_den_d = {23'd0, wsz - 9'd1};
        div_rem_d = 32'd0;
        cnt_d     = 6'd0;
      end
      dqw_pkg::S_DIV_X: begin
        div_rem_d = div_rem_n;
        div_quo_d = div_quo_n;
        cnt_d     = cnt_q + 6'd1;
        if (div_done) begin
          dx_d      = (wsz == 9'd1) ? 17'd0 : div_quo_n[16:0];
          div_quo_d = {24'd0, ypos, 16'd0};
          div_den_d = {23'd0, hsz - 9'd1};
          div_rem_d = 32'd0;
          cnt_d     = 6'd0;
        end
      end
      dqw_pkg::S_DIV_Y: begin
        div_rem_d = div_rem_n;
        div_quo_d = div_quo_n;
        cnt_d     = cnt_q + 6'd1;
        if (div_done) dy_d = (hsz == 9'd1) ? 17'd0 : div_quo_n[16:0];
      end
      dqw_pkg::S_SQ_X: begin
        mul_a  = {15'd0, dx_q};
        mul_b  = {15'd0, dx_q};
        sq_v_d = mul_p[33:0];
      end
      dqw_pkg::S_SQ_Y: begin
        mul_a  = {15'd0, dy_q};
        mul_b  = {15'd0, dy_q};
        sq_v_d = sq_v_q + mul_p[33:0];
        sq_r_d = 34'd0;
        sq_b_d = 34'd1 << 32;
      end
      dqw_pkg::S_SQRT: begin
        if (sq_ge) sq_v_d = sq_v_q - sq_sum;
        sq_r_d = sq_r_n;
        sq_b_d = sq_b_q >> 2;
      end
      dqw_pkg::S_SP_MUL: begin
        mul_a     = {15'd0, sq_r_q[16:0]};
        mul_b     = 32'(n_q) - 32'd1;
        div_quo_d = {mul_p[31:0], 16'd0};
      end
      // estimate of the band position by the reciprocal of the full distance
      dqw_pkg::S_SP_RCP: begin
        mul_a = div_quo_q[47:16];
        mul_b = dqw_pkg::DIST_RECIP;
        sp_d  = mul_p[63:32];
      end
      // remainder of the estimate
      dqw_pkg::S_SP_FIX: begin
        mul_a     = sp_q;
        mul_b     = dqw_pkg::MAX_DIST_Q16;
        div_rem_d = 32'(div_quo_q - mul_p[47:0]);
      end
      dqw_pkg::S_SP_ADJ: begin
        idx_d = sp_fix[16 +: BW];
        fr_d  = sp_fix[15:0];
      end
      dqw_pkg::S_SEL: ;
      dqw_pkg::S_RD_EDGE: mem_ra = BW'(n_q - NW'(1));
      dqw_pkg::S_EDGE: res_d = dqw_pkg::clamp_weight(rd_q);
      dqw_pkg::S_RD_A: mem_ra = idx_q;
      dqw_pkg::S_RD_B: begin
        a_d    = rd_q;
        mem_ra = idx_q + BW'(1);
      end
      dqw_pkg::S_CHECK: begin
        b_d      = rd_q;
        res_d    = dqw_pkg::clamp_weight(a_q);
        m_d      = a_q;
        p_d      = 5'd30;
        second_d = 1'b0;
      end
      dqw_pkg::S_NORM: begin
        if (m_q[30]) begin
          cnt_d = 6'd0;
          f_d   = 24'd0;
        end else begin
          m_d = m_q << 1;
          p_d = p_q - 5'd1;
        end
      end
      dqw_pkg::S_LOG: begin
        mul_a = m_q;
        mul_b = m_q;
        m_d   = log_mm[31] ? (log_mm >> 1) : log_mm;
        f_d   = log_f_n;
        cnt_d = cnt_q + 6'd1;
        if (log_done) begin
          if (!second_q) begin
            la_d     = $signed({log_pm16, log_f_n});
            m_d      = b_q;
            p_d      = 5'd30;
            second_d = 1'b1;
          end else begin
            lb_d = $signed({log_pm16, log_f_n});
          end
        end
      end
      dqw_pkg::S_INTERP: begin
        mul_a = {16'd0, fr_q};
        mul_b = lg_mag;
        t_d   = lg_diff[30] ? (la_ext - $signed(mul_p[47:0]))
                            : (la_ext + $signed(mul_p[47:0]));
        e_d   = dqw_pkg::ONE_Q30;
        cnt_d = 6'd0;
      end
      dqw_pkg::S_POW: begin
        mul_a = e_q;
        mul_b = dqw_pkg::POW2_C[cnt_q[4:0]];
        if (pow_bit) e_d = mul_p[61:30];
        cnt_d = cnt_q + 6'd1;
      end
      dqw_pkg::S_SHIFT: res_d = sh_res;
      dqw_pkg::S_FINISH: ;
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_w_d     = out_w_q;
    out_e_d     = out_e_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    if (state_q == dqw_pkg::S_FINISH && out_free) begin
      out_valid_d = 1'b1;
      out_w_d     = res_q;
      out_e_d     = err_q;
    end
  end

  assign s_axis_tready = state_q == dqw_pkg::S_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_e_q, out_w_q};
  assign cfg_ready_o   = 1'b1;

  // band table write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) band_mem[BW'(bidx_q)] <= band_q;
    rd_q <= band_mem[mem_ra];
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dqw_pkg::S_IDLE;
      mw_q        <= 9'd8;
      mh_q        <= 9'd8;
      bc_q        <= 5'd1;
      err_q       <= 1'b0;
      prev_q      <= 32'sd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      err_q       <= err_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          dqw_pkg::REG_WIDTH:  mw_q <= cfg_data_i;
          dqw_pkg::REG_HEIGHT: mh_q <= cfg_data_i;
          dqw_pkg::REG_BANDS:  bc_q <= cfg_data_i[4:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    band_q    <= band_d;    neg_q     <= neg_d;     bidx_q   <= bidx_d;
    x_q       <= x_d;       col_q     <= col_d;     row_q    <= row_d;
    cnt_q     <= cnt_d;     div_rem_q <= div_rem_d; div_quo_q <= div_quo_d;
    div_den_q <= div_den_d; dx_q      <= dx_d;      dy_q     <= dy_d;
    sq_v_q    <= sq_v_d;    sq_r_q    <= sq_r_d;    sq_b_q   <= sq_b_d;
    n_q       <= n_d;       idx_q     <= idx_d;     fr_q     <= fr_d;
    sp_q      <= sp_d;
    a_q       <= a_d;       b_q       <= b_d;       m_q      <= m_d;
    p_q       <= p_d;       f_q       <= f_d;       la_q     <= la_d;
    lb_q      <= lb_d;      second_q  <= second_d;  t_q      <= t_d;
    e_q       <= e_d;       res_q     <= res_d;
    out_w_q   <= out_w_d;   out_e_q   <= out_e_d;
  end

endmodule
